// ----- rtl/core/srh_pkg.sv -----
// shared types and constants for the segment rectangle hit unit
package srh_pkg;

  localparam int unsigned CoordW    = 32;
  localparam int unsigned DeltaW    = CoordW + 1;
  localparam int unsigned ProdW     = 2 * DeltaW;
  localparam int unsigned QuotW     = 34;
  localparam int unsigned SumW      = QuotW + 2;
  localparam int unsigned LaneLat   = QuotW + 4;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = 2;
  localparam int unsigned FifoCntW  = 3;
  localparam int unsigned NumLanes  = 3;

  typedef enum logic [1:0] {
    EDGE_MAX_Y = 2'd0,
    EDGE_MIN_X = 2'd1,
    EDGE_MAX_X = 2'd2,
    EDGE_MIN_Y = 2'd3
  } edge_e;

  typedef struct packed {
    logic [CoordW-1:0] start_x;
    logic [CoordW-1:0] start_y;
    logic [CoordW-1:0] end_x;
    logic [CoordW-1:0] end_y;
    logic [CoordW-1:0] box_min_x;
    logic [CoordW-1:0] box_min_y;
    logic [CoordW-1:0] box_max_x;
    logic [CoordW-1:0] box_max_y;
  } srh_in_t;

  typedef struct packed {
    logic              hit;
    logic [CoordW-1:0] hit_x;
    logic [CoordW-1:0] hit_y;
    logic [1:0]        hit_edge;
  } srh_out_t;

  // one crossing candidate: base + trunc(a * b / d), kept if lo < result < hi
  typedef struct packed {
    logic              en;
    logic [DeltaW-1:0] a;
    logic [DeltaW-1:0] b;
    logic [DeltaW-1:0] d;
    logic [CoordW-1:0] base;
    logic [CoordW-1:0] lo;
    logic [CoordW-1:0] hi;
    logic [CoordW-1:0] fixed;
  } lane_req_t;

  typedef struct packed {
    logic              hit;
    logic [CoordW-1:0] coord;
    logic [CoordW-1:0] fixed;
  } lane_res_t;

  typedef struct packed {
    lane_req_t [NumLanes-1:0] lanes;
    edge_e                    edge_a;
  } srh_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

// ----- rtl/core/segment_rectangle_hit_unit.sv -----
// top level of the segment rectangle hit unit
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid_i/in_ready_o | in_data_i (srh_in_t)
//  out     | output    | out_valid_o/out_ready_i | out_data_o (srh_out_t)
//
// one transaction per cycle sustained while the output is not stalled; path from
// input accept to output valid: front register, queue, 38-stage lane (multiply
// plus a 34-stage one-bit-per-stage divider and span test) and output register.
// reset clears only control state; the queue holds four transactions.
// an output stall freezes the lanes; the queue and front keep accepting until full.
module segment_rectangle_hit_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  srh_pkg::srh_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output srh_pkg::srh_out_t  out_data_o
);

  logic                  push, pop, fifo_valid;
  srh_pkg::srh_item_t    front_item, fifo_item;
  srh_pkg::fifo_stat_t   fifo_stat;

  srh_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .fifo_full_i (fifo_stat.full),
    .push_o      (push),
    .item_o      (front_item)
  );

  srh_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_item),
    .pop_i   (pop),
    .valid_o (fifo_valid),
    .data_o  (fifo_item),
    .stat_o  (fifo_stat)
  );

  srh_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_valid_i (fifo_valid),
    .item_i       (fifo_item),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.hit |->
      out_data_o.hit_x == '0 && out_data_o.hit_y == '0 && out_data_o.hit_edge == '0)
    else $error("miss result carries nonzero fields");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !fifo_stat.full)
    else $error("push into full queue");

  a_stat_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fifo_stat.full && fifo_stat.empty))
    else $error("queue both full and empty");

endmodule

// ----- rtl/core/srh_front.sv -----
// front end: accepts queries and classifies them into crossing candidates
module srh_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  srh_pkg::srh_in_t  in_data_i,
  input  logic              fifo_full_i,
  output logic              push_o,
  output srh_pkg::srh_item_t item_o
);

  logic                  valid_q;
  srh_pkg::srh_item_t    item_q, item_d;
  logic signed [31:0]    sx, sy, ex, ey, bx0, by0, bx1, by1;
  logic signed [32:0]    dx, dy;
  logic                  trivial, above, below, left_of;
  logic [31:0]           hy;

  always_comb begin
    sx  = $signed(in_data_i.start_x);
    sy  = $signed(in_data_i.start_y);
    ex  = $signed(in_data_i.end_x);
    ey  = $signed(in_data_i.end_y);
    bx0 = $signed(in_data_i.box_min_x);
    by0 = $signed(in_data_i.box_min_y);
    bx1 = $signed(in_data_i.box_max_x);
    by1 = $signed(in_data_i.box_max_y);
    dx  = $signed({ex[31], ex}) - $signed({sx[31], sx});
    dy  = $signed({ey[31], ey}) - $signed({sy[31], sy});
    trivial = (sx <= bx0 && ex <= bx0) || (sy <= by0 && ey <= by0) ||
              (sx >= bx1 && ex >= bx1) || (sy >= by1 && ey >= by1);
    above   = sy > by1;
    below   = sy < by0;
    left_of = sx < bx0;
    hy      = above ? in_data_i.box_max_y : in_data_i.box_min_y;

    item_d.edge_a = above ? srh_pkg::EDGE_MAX_Y : srh_pkg::EDGE_MIN_Y;

    // horizontal edge
    item_d.lanes[0].en    = !trivial && (above || below) && (dy != '0);
    item_d.lanes[0].a     = dx;
    item_d.lanes[0].b     = $signed({hy[31], hy}) - $signed({sy[31], sy});
    item_d.lanes[0].d     = dy;
    item_d.lanes[0].base  = in_data_i.start_x;
    item_d.lanes[0].lo    = in_data_i.box_min_x;
    item_d.lanes[0].hi    = in_data_i.box_max_x;
    item_d.lanes[0].fixed = hy;

    // min-x edge
    item_d.lanes[1].en    = !trivial && (above || below || left_of) && (dx != '0);
    item_d.lanes[1].a     = dy;
    item_d.lanes[1].b     = $signed({bx0[31], bx0}) - $signed({sx[31], sx});
    item_d.lanes[1].d     = dx;
    item_d.lanes[1].base  = in_data_i.start_y;
    item_d.lanes[1].lo    = in_data_i.box_min_y;
    item_d.lanes[1].hi    = in_data_i.box_max_y;
    item_d.lanes[1].fixed = in_data_i.box_min_x;

    // max-x edge
    item_d.lanes[2].en    = !trivial && (above || below || !left_of) && (dx != '0);
    item_d.lanes[2].a     = dy;
    item_d.lanes[2].b     = $signed({bx1[31], bx1}) - $signed({sx[31], sx});
    item_d.lanes[2].d     = dx;
    item_d.lanes[2].base  = in_data_i.start_y;
    item_d.lanes[2].lo    = in_data_i.box_min_y;
    item_d.lanes[2].hi    = in_data_i.box_max_y;
    item_d.lanes[2].fixed = in_data_i.box_max_x;
  end

  assign in_ready_o = !valid_q || !fifo_full_i;
  assign push_o     = valid_q && !fifo_full_i;
  assign item_o     = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      valid_q <= 1'b1;
    end else if (push_o) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_d;
    end
  end

endmodule

// ----- rtl/core/srh_fifo.sv -----
// short queue between the front end and the back end
module srh_fifo (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  srh_pkg::srh_item_t      data_i,
  input  logic                    pop_i,
  output logic                    valid_o,
  output srh_pkg::srh_item_t      data_o,
  output srh_pkg::fifo_stat_t     stat_o
);

  srh_pkg::srh_item_t                  mem [srh_pkg::FifoDepth];
  logic [srh_pkg::FifoPtrW-1:0]        wr_ptr_q, rd_ptr_q;
  logic [srh_pkg::FifoCntW-1:0]        cnt_q;
  logic                                do_push, do_pop;

  assign stat_o.full  = cnt_q == srh_pkg::FifoCntW'(srh_pkg::FifoDepth);
  assign stat_o.empty = cnt_q == '0;
  assign valid_o      = !stat_o.empty;
  assign data_o       = mem[rd_ptr_q];
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- rtl/core/srh_lane.sv -----
// one crossing lane: multiply, pipelined restoring divide, span test
module srh_lane (
  input  logic                  clk_i,
  input  logic                  adv_i,
  input  srh_pkg::lane_req_t    req_i,
  output srh_pkg::lane_res_t    res_o
);

  localparam int unsigned QW = srh_pkg::QuotW;

  typedef struct packed {
    logic        en;
    logic        neg;
    logic [31:0] base;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] fixed;
  } ctl_t;

  ctl_t                         ctl1_q, ctl2_q;
  logic [32:0]                  ua_q, ub_q, ud1_q, ud2_q;
  logic [srh_pkg::ProdW-1:0]    prod_q;

  ctl_t                         ctl_q  [QW+1];
  logic [32:0]                  ud_q   [QW+1];
  logic [32:0]                  rem_q  [QW+1];
  logic [QW-1:0]                low_q  [QW+1];
  logic [QW-1:0]                quo_q  [QW+1];
  logic                         ovf_q  [QW+1];

  ctl_t                         ctl_s1;
  logic [32:0]                  ua_d, ub_d, ud_d;
  logic                         ovf_d;
  logic signed [srh_pkg::SumW-1:0] sq, sum, lo_x, hi_x;
  srh_pkg::lane_res_t           res_q, res_d;

  always_comb begin
    ua_d          = req_i.a[32] ? 33'(-req_i.a) : req_i.a;
    ub_d          = req_i.b[32] ? 33'(-req_i.b) : req_i.b;
    ud_d          = req_i.d[32] ? 33'(-req_i.d) : req_i.d;
    ctl_s1.en     = req_i.en;
    ctl_s1.neg    = req_i.a[32] ^ req_i.b[32] ^ req_i.d[32];
    ctl_s1.base   = req_i.base;
    ctl_s1.lo     = req_i.lo;
    ctl_s1.hi     = req_i.hi;
    ctl_s1.fixed  = req_i.fixed;
    // quotient bits above the kept ones: the crossing is far outside any span
    ovf_d = {2'b00, prod_q[srh_pkg::ProdW-1:QW]} >= {1'b0, ud2_q};
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ua_q   <= ua_d;
      ub_q   <= ub_d;
      ud1_q  <= ud_d;
      ctl1_q <= ctl_s1;
      prod_q <= ua_q * ub_q;
      ud2_q  <= ud1_q;
      ctl2_q <= ctl1_q;
      ctl_q[0] <= ctl2_q;
      ud_q[0]  <= ud2_q;
      ovf_q[0] <= ovf_d;
      rem_q[0] <= ovf_d ? '0 : 33'(prod_q[srh_pkg::ProdW-1:QW]);
      low_q[0] <= prod_q[QW-1:0];
      quo_q[0] <= '0;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [33:0] trial;
    logic        ge;
    assign trial = {rem_q[k], low_q[k][QW-1]};
    assign ge    = trial >= {1'b0, ud_q[k]};
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        ctl_q[k+1] <= ctl_q[k];
        ud_q[k+1]  <= ud_q[k];
        ovf_q[k+1] <= ovf_q[k];
        rem_q[k+1] <= ge ? 33'(trial - {1'b0, ud_q[k]}) : trial[32:0];
        low_q[k+1] <= {low_q[k][QW-2:0], 1'b0};
        quo_q[k+1] <= {quo_q[k][QW-2:0], ge};
      end
    end
  end

  always_comb begin
    sq   = ctl_q[QW].neg ? -$signed({2'b00, quo_q[QW]}) : $signed({2'b00, quo_q[QW]});
    sum  = $signed({{(srh_pkg::SumW-32){ctl_q[QW].base[31]}}, ctl_q[QW].base}) + sq;
    lo_x = $signed({{(srh_pkg::SumW-32){ctl_q[QW].lo[31]}}, ctl_q[QW].lo});
    hi_x = $signed({{(srh_pkg::SumW-32){ctl_q[QW].hi[31]}}, ctl_q[QW].hi});
    res_d.hit   = ctl_q[QW].en && !ovf_q[QW] && (sum > lo_x) && (sum < hi_x);
    res_d.coord = sum[31:0];
    res_d.fixed = ctl_q[QW].fixed;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// ----- rtl/core/srh_back.sv -----
// back end: three crossing lanes, first-hit select and output register
module srh_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fifo_valid_i,
  input  srh_pkg::srh_item_t    item_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output srh_pkg::srh_out_t     out_data_o
);

  localparam int unsigned Lat = srh_pkg::LaneLat;

  logic                     adv;
  logic [Lat-1:0]           vld_q;
  srh_pkg::edge_e           tag_q [Lat];
  srh_pkg::lane_res_t       res [srh_pkg::NumLanes];
  logic                     out_valid_q;
  srh_pkg::srh_out_t        out_q, out_d;

  // whole pipeline moves only when the output register can take a result
  assign adv   = !out_valid_q || out_ready_i;
  assign pop_o = adv;

  for (genvar l = 0; l < srh_pkg::NumLanes; l++) begin : g_lane
    srh_lane u_lane (
      .clk_i (clk_i),
      .adv_i (adv),
      .req_i (item_i.lanes[l]),
      .res_o (res[l])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      vld_q       <= {vld_q[Lat-2:0], fifo_valid_i};
      out_valid_q <= vld_q[Lat-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tag_q[0] <= item_i.edge_a;
      for (int k = 1; k < Lat; k++) begin
        tag_q[k] <= tag_q[k-1];
      end
      out_q <= out_d;
    end
  end

  always_comb begin
    out_d = '0;
    if (res[0].hit) begin
      out_d.hit      = 1'b1;
      out_d.hit_x    = res[0].coord;
      out_d.hit_y    = res[0].fixed;
      out_d.hit_edge = tag_q[Lat-1];
    end else if (res[1].hit) begin
      out_d.hit      = 1'b1;
      out_d.hit_x    = res[1].fixed;
      out_d.hit_y    = res[1].coord;
      out_d.hit_edge = srh_pkg::EDGE_MIN_X;
    end else if (res[2].hit) begin
      out_d.hit      = 1'b1;
      out_d.hit_x    = res[2].fixed;
      out_d.hit_y    = res[2].coord;
      out_d.hit_edge = srh_pkg::EDGE_MAX_X;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- tb/segment_rectangle_hit_unit_tb.sv -----
// testbench for the segment rectangle hit unit: predicted crossings vs. dut results
`timescale 1ns / 100ps

module segment_rectangle_hit_unit_tb;

  // expected crossing results in arrival order
  class hit_scoreboard;
    srh_pkg::srh_out_t pending_hits[$];
    int errors;

    // trunc(a * b / d) held at +-2^62
    static function longint scaled_quot(longint a, longint b, longint d);
      logic [127:0] prod, q;
      logic neg;
      longint ua, ub, ud;
      neg = ((a < 0) != (b < 0)) != (d < 0);
      ua = (a < 0) ? -a : a;
      ub = (b < 0) ? -b : b;
      ud = (d < 0) ? -d : d;
      prod = 128'(ua) * 128'(ub);
      q = prod / 128'(ud);
      if (q > (128'd1 << 62)) q = 128'd1 << 62;
      return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    static function srh_pkg::srh_out_t predict_hit(srh_pkg::srh_in_t t);
      longint sx, sy, ex, ey, bx0, by0, bx1, by1, dx, dy, v;
      srh_pkg::srh_out_t r;
      logic found;
      srh_pkg::edge_e e;
      longint px, py;
      sx = longint'($signed(t.start_x));
      sy = longint'($signed(t.start_y));
      ex = longint'($signed(t.end_x));
      ey = longint'($signed(t.end_y));
      bx0 = longint'($signed(t.box_min_x));
      by0 = longint'($signed(t.box_min_y));
      bx1 = longint'($signed(t.box_max_x));
      by1 = longint'($signed(t.box_max_y));
      dx = ex - sx;
      dy = ey - sy;
      found = 0;
      e = srh_pkg::EDGE_MAX_Y;
      px = 0;
      py = 0;
      r = '0;
      if ((sx <= bx0 && ex <= bx0) || (sy <= by0 && ey <= by0) ||
          (sx >= bx1 && ex >= bx1) || (sy >= by1 && ey >= by1)) return r;
      // edges tried in order; first crossing inside its span wins
      for (int k = 0; k < 3 && !found; k++) begin
        srh_pkg::edge_e cand;
        if (sy > by1) cand = (k == 0) ? srh_pkg::EDGE_MAX_Y :
                             (k == 1) ? srh_pkg::EDGE_MIN_X : srh_pkg::EDGE_MAX_X;
        else if (sy < by0) cand = (k == 0) ? srh_pkg::EDGE_MIN_Y :
                                  (k == 1) ? srh_pkg::EDGE_MIN_X : srh_pkg::EDGE_MAX_X;
        else begin
          if (k > 0) break;
          cand = (sx < bx0) ? srh_pkg::EDGE_MIN_X : srh_pkg::EDGE_MAX_X;
        end
        if (cand == srh_pkg::EDGE_MAX_Y || cand == srh_pkg::EDGE_MIN_Y) begin
          longint yl;
          yl = (cand == srh_pkg::EDGE_MAX_Y) ? by1 : by0;
          if (dy != 0) begin
            v = sx + scaled_quot(dx, yl - sy, dy);
            if (v > bx0 && v < bx1) begin
              found = 1; px = v; py = yl; e = cand;
            end
          end
        end else begin
          longint xl;
          xl = (cand == srh_pkg::EDGE_MIN_X) ? bx0 : bx1;
          if (dx != 0) begin
            v = sy + scaled_quot(dy, xl - sx, dx);
            if (v > by0 && v < by1) begin
              found = 1; px = xl; py = v; e = cand;
            end
          end
        end
      end
      if (found) begin
        r.hit = 1'b1;
        r.hit_x = px[31:0];
        r.hit_y = py[31:0];
        r.hit_edge = e;
      end
      return r;
    endfunction

    function void note_query(srh_pkg::srh_in_t t);
      pending_hits.push_back(predict_hit(t));
    endfunction

    function void check_hit(srh_pkg::srh_out_t got);
      srh_pkg::srh_out_t exp_r;
      if (pending_hits.size() == 0) begin
        $display("%0t: unexpected transaction %h", $time, got);
        errors++;
        return;
      end
      exp_r = pending_hits.pop_front();
      if (got.hit !== exp_r.hit || got.hit_x !== exp_r.hit_x ||
          got.hit_y !== exp_r.hit_y || got.hit_edge !== exp_r.hit_edge) begin
        $display("%0t: mismatch expected hit=%b x=%h y=%h edge=%0d %s",
                 $time, exp_r.hit, exp_r.hit_x, exp_r.hit_y, exp_r.hit_edge,
                 $sformatf("actual hit=%b x=%h y=%h edge=%0d",
                           got.hit, got.hit_x, got.hit_y, got.hit_edge));
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic in_valid_i = 0;
  logic in_ready_o;
  srh_pkg::srh_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 0;
  srh_pkg::srh_out_t out_data_o;

  hit_scoreboard board = new();
  bit quiet_phase = 0;
  longint cycles = 0;

  always #10 clk_i = ~clk_i;

  segment_rectangle_hit_unit dut (.*);

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // receiver: check accepted results, stall in random bursts
  int stall_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) board.check_hit(out_data_o);
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 3);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // valid stays high into the next transaction unless an idle burst comes
  task automatic send_query(srh_pkg::srh_in_t t);
    if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= t;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_query(t);
  endtask

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 4000)) - 2000) <<< 8;
      default: return 32'($signed($urandom_range(0, 200)) - 100);
    endcase
  endfunction

  // mostly segments around a sane box so crossings happen
  function automatic srh_pkg::srh_in_t rand_query();
    srh_pkg::srh_in_t t;
    int m;
    m = $urandom_range(0, 9);
    t.start_x = rand_coord(m == 0 ? 0 : (m < 6 ? 1 : 2));
    t.start_y = rand_coord(m == 0 ? 0 : (m < 6 ? 1 : 2));
    t.end_x = rand_coord(m == 0 ? 0 : (m < 6 ? 1 : 2));
    t.end_y = rand_coord(m == 0 ? 0 : (m < 6 ? 1 : 2));
    if (m == 0 || m == 9) begin
      t.box_min_x = rand_coord(m == 0 ? 0 : 2);
      t.box_min_y = rand_coord(m == 0 ? 0 : 2);
      t.box_max_x = rand_coord(m == 0 ? 0 : 2);
      t.box_max_y = rand_coord(m == 0 ? 0 : 2);
    end else begin
      t.box_min_x = -32'sd1 * $urandom_range(1, 300000);
      t.box_min_y = -32'sd1 * $urandom_range(1, 300000);
      t.box_max_x = $urandom_range(1, 300000);
      t.box_max_y = $urandom_range(1, 300000);
    end
    if ($urandom_range(0, 15) == 0) t.end_x = t.start_x;
    if ($urandom_range(0, 15) == 0) t.end_y = t.start_y;
    if ($urandom_range(0, 15) == 0) t.start_x = t.box_min_x;
    if ($urandom_range(0, 15) == 0) t.end_y = t.box_max_y;
    return t;
  endfunction

  function automatic srh_pkg::srh_in_t make_query(int sx, int sy, int ex, int ey,
                                                  int x0, int y0, int x1, int y1);
    srh_pkg::srh_in_t t;
    t = {sx, sy, ex, ey, x0, y0, x1, y1};
    return t;
  endfunction

  localparam int MinC = 32'h8000_0000;
  localparam int MaxC = 32'h7fff_ffff;

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: each edge, order cases, degenerate segments and boxes, extremes
    send_query(make_query(0, 200, 0, -200, -100, -100, 100, 100));    // vertical from above
    send_query(make_query(10, -200, 20, 200, -100, -100, 100, 100));  // from below
    send_query(make_query(-200, 0, 200, 5, -100, -100, 100, 100));    // from left
    send_query(make_query(0, 0, 300, 7, -100, -100, 100, 100));       // inside to right
    send_query(make_query(-300, 300, 0, 0, -100, -100, 100, 100));    // above, top-left corner
    send_query(make_query(300, 300, 0, 0, -100, -100, 100, 100));     // above, top-right corner
    send_query(make_query(-300, -300, 0, 0, -100, -100, 100, 100));   // below, left
    send_query(make_query(300, -300, 0, 0, -100, -100, 100, 100));    // below, right
    send_query(make_query(-200, 0, 200, 0, -100, -100, 100, 100));    // horizontal
    send_query(make_query(-200, 50, -100, 60, -100, -100, 100, 100)); // ends on min x
    send_query(make_query(-200, 0, 200, 0, 100, -100, -100, 100));    // inverted box
    send_query(make_query(-200, 0, 200, 0, 0, 0, 0, 0));              // empty box
    send_query(make_query(MinC, MinC, MaxC, MaxC, MinC, MinC, MaxC, MaxC));
    send_query(make_query(MaxC, MaxC, MinC, MinC, MinC, MinC, MaxC, MaxC));
    send_query(make_query(MinC, 0, MaxC, 1, -5, MinC, 5, MaxC));      // wide dx, tiny dy
    send_query(make_query(MaxC, MinC, MinC, MaxC, -1, -1, 1, 1));
    send_query(make_query(0, MaxC, 1, MinC, MinC, -10, MaxC, 10));
    send_query(make_query(-1, -1, -1, -1, MinC, MinC, MaxC, MaxC));   // point inside
    send_query(make_query(MinC, MaxC, MaxC, MinC, 0, 0, MaxC, MaxC));
    for (int i = 0; i < 1930; i++) begin
      if (i == 900) begin
        // hold off until the unit drains
        in_valid_i <= 1'b0;
        while (board.pending_hits.size() != 0) @(posedge clk_i);
        @(posedge clk_i);
      end
      if (i == 1700) quiet_phase = 1;
      send_query(rand_query());
    end
    in_valid_i <= 1'b0;
    while (board.pending_hits.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (board.errors == 0 && board.pending_hits.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/srh_pkg.sv
rtl/core/srh_front.sv
rtl/core/srh_fifo.sv
rtl/core/srh_lane.sv
rtl/core/srh_back.sv
rtl/core/segment_rectangle_hit_unit.sv
tb/segment_rectangle_hit_unit_tb.sv
